// ===== hdl/pcc_pkg.sv =====
// Shared types and constants of the Pearson correlation core.
// Holds the controller command and status structs and the fixed result widths.
// Depends on nothing; every other file of the core but pcc_in_if refers to it by scoped names.
package pcc_pkg;

	// Result field widths, fixed by the output format.
	localparam int CORR_W      = 16;
	localparam int COUNT_OUT_W = 11;
	localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;

	// The ratio is taken as isqrt(floor(2^32 * c^2 / (vx * vy))), so the
	// quotient needs 33 bits and its square root 17 bits.
	localparam int RATIO_SHIFT = 32;
	localparam int QUO_W       = RATIO_SHIFT + 1;
	localparam int SQRT_IN_W   = QUO_W + 1;
	localparam int SQRT_STEPS  = QUO_W / 2 + 1;
	localparam int ROOT_W      = SQRT_STEPS;
	localparam int STEP_CNT_W  = 6;

	// Bits of the multiplier operand consumed per cycle.
	localparam int MUL_DIGIT_W = 8;

	// Product selector: picks the operand pair and the register written back.
	typedef enum logic [2:0] {
		MS_N_SXY,
		MS_SX_SY,
		MS_N_SXX,
		MS_SX_SX,
		MS_N_SYY,
		MS_SY_SY,
		MS_VX_VY,
		MS_C_C
	} mul_sel_t;

	typedef struct packed {
		logic     acc_en;
		logic     mul_start;
		logic     mul_wb;
		mul_sel_t mul_sel;
		logic     root_start;
		logic     out_load;
	} pcc_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic root_done;
		logic degenerate;
	} pcc_status_t;

endpackage

// ===== hdl/pcc_in_if.sv =====
// Input channel of the Pearson correlation core: one sample pair per transaction.
// Carries valid, ready and the payload; no package dependency.
interface pcc_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] x_sample;
	logic signed [SAMPLE_WIDTH-1:0] y_sample;
	logic                           last;

	modport source (output valid, x_sample, y_sample, last, input ready);
	modport sink (input valid, x_sample, y_sample, last, output ready);
endinterface

// ===== hdl/pcc_out_if.sv =====
// Result channel of the Pearson correlation core: one coefficient per transaction.
// Carries valid, ready and the payload; widths follow pcc_pkg.
interface pcc_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pcc_pkg::CORR_W-1:0]      corr;
	logic                                   degenerate;
	logic                                   overflowed;
	logic        [pcc_pkg::COUNT_OUT_W-1:0] sample_count;

	modport source (output valid, corr, degenerate, overflowed, sample_count, input ready);
	modport sink (input valid, corr, degenerate, overflowed, sample_count, output ready);
endinterface

// ===== hdl/pcc_mul.sv =====
// Iterative unsigned multiplier of the Pearson correlation core.
// Consumes one digit of the second operand per cycle, most significant first.
// Depends on pcc_pkg for the digit width.
module pcc_mul #(
	parameter int OP_W = 52
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OP_W-1:0]   a,
	input  logic [OP_W-1:0]   b,
	output logic              done,
	output logic [2*OP_W-1:0] prod
);
	localparam int DW    = pcc_pkg::MUL_DIGIT_W;
	localparam int STEPS = (OP_W + DW - 1) / DW;
	localparam int BQ_W  = STEPS * DW;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int ACC_W = 2 * OP_W;
	localparam int PP_W  = OP_W + DW;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OP_W-1:0]  a_q;
	logic [BQ_W-1:0]  b_q;
	logic [ACC_W-1:0] acc_q;
	logic [DW-1:0]    digit;
	logic [PP_W-1:0]  pp;

	assign digit = b_q[BQ_W-1 -: DW];
	assign pp    = {{DW{1'b0}}, a_q} * {{OP_W{1'b0}}, digit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// Done pulses for one cycle after the last digit has been folded in.
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= BQ_W'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << DW) + ACC_W'(pp);
			b_q   <= b_q << DW;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== hdl/pcc_root.sv =====
// Ratio unit of the Pearson correlation core: restoring divide, then integer square root.
// Returns k = floor((isqrt(floor(m * 2^32 / p)) + 1) / 2), one bit per cycle.
// Depends on pcc_pkg for the quotient and root widths.
module pcc_root #(
	parameter int P_W = 104
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [P_W-1:0]             p,
	input  logic [P_W-1:0]             m,
	output logic                       done,
	output logic [pcc_pkg::CORR_W-1:0] k
);
	localparam int R_W  = P_W + pcc_pkg::RATIO_SHIFT + 1;
	localparam int Q_W  = pcc_pkg::QUO_W;
	localparam int S_W  = pcc_pkg::SQRT_IN_W;
	localparam int C_W  = pcc_pkg::STEP_CNT_W;
	localparam int RT_W = pcc_pkg::ROOT_W;
	localparam logic [S_W-1:0] BIT_INIT = S_W'(1) << (2 * (pcc_pkg::SQRT_STEPS - 1));

	typedef enum logic [1:0] {
		RT_IDLE,
		RT_DIV,
		RT_SQRT
	} root_state_t;

	root_state_t    state_q;
	logic [C_W-1:0] cnt_q;
	logic           done_q;

	logic [R_W-1:0]  rem_q;
	logic [R_W-1:0]  den_q;
	logic [Q_W-1:0]  quo_q;
	logic [S_W-1:0]  sq_rem_q;
	logic [S_W-1:0]  res_q;
	logic [S_W-1:0]  bit_q;

	logic            ge;
	logic [Q_W-1:0]  quo_next;
	logic [S_W-1:0]  trial;
	logic            take;
	logic [RT_W:0]   k_sum;

	assign ge       = rem_q >= den_q;
	assign quo_next = {quo_q[Q_W-2:0], ge};
	assign trial    = res_q + bit_q;
	assign take     = sq_rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RT_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			// Done pulses once, right after the last root step.
			done_q <= (state_q == RT_SQRT) && (cnt_q == '0);
			case (state_q)
				RT_IDLE: begin
					if (start) begin
						state_q <= RT_DIV;
						cnt_q   <= C_W'(Q_W - 1);
					end
				end
				RT_DIV: begin
					if (cnt_q == '0) begin
						state_q <= RT_SQRT;
						cnt_q   <= C_W'(pcc_pkg::SQRT_STEPS - 1);
					end else begin
						cnt_q <= cnt_q - C_W'(1);
					end
				end
				RT_SQRT: begin
					cnt_q <= cnt_q - C_W'(1);
					if (cnt_q == '0) begin
						state_q <= RT_IDLE;
					end
				end
				default: begin
					state_q <= RT_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			RT_IDLE: begin
				if (start) begin
					rem_q <= {1'b0, m, {pcc_pkg::RATIO_SHIFT{1'b0}}};
					den_q <= {1'b0, p, {pcc_pkg::RATIO_SHIFT{1'b0}}};
					quo_q <= '0;
				end
			end
			RT_DIV: begin
				if (ge) begin
					rem_q <= rem_q - den_q;
				end
				den_q <= den_q >> 1;
				quo_q <= quo_next;
				if (cnt_q == '0) begin
					sq_rem_q <= {1'b0, quo_next};
					res_q    <= '0;
					bit_q    <= BIT_INIT;
				end
			end
			RT_SQRT: begin
				if (take) begin
					sq_rem_q <= sq_rem_q - trial;
					res_q    <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: begin
			end
		endcase
	end

	// Largest odd t not above the root is the root or one below; k = (t + 1) / 2.
	assign k_sum = {1'b0, res_q[RT_W-1:0]} + (RT_W + 1)'(1);
	assign k     = k_sum[pcc_pkg::CORR_W:1];
	assign done  = done_q;

endmodule

// ===== hdl/pcc_datapath.sv =====
// Datapath of the Pearson correlation core: accumulators, product and ratio units, result register.
// Driven by pcc_ctrl through pcc_pkg::pcc_cmd_t and reporting through pcc_pkg::pcc_status_t.
// Instantiates pcc_mul and pcc_root.
module pcc_datapath #(
	parameter int MAX_SAMPLES  = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pcc_pkg::pcc_cmd_t                   cmd,
	output pcc_pkg::pcc_status_t                status,
	input  logic signed [SAMPLE_WIDTH-1:0]      x_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]      y_sample,
	output logic signed [pcc_pkg::CORR_W-1:0]   corr,
	output logic                                degenerate,
	output logic                                overflowed,
	output logic [pcc_pkg::COUNT_OUT_W-1:0]     sample_count
);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int PW     = 2 * SAMPLE_WIDTH;
	localparam int SUM_W  = CNT_W + SAMPLE_WIDTH;
	localparam int SQ_W   = CNT_W + 2 * SAMPLE_WIDTH - 1;
	localparam int VAR_W  = 2 * CNT_W + 2 * SAMPLE_WIDTH - 2;
	localparam int PROD_W = VAR_W + 2;
	localparam int OP_W   = VAR_W;
	localparam int P_W    = 2 * OP_W;
	localparam int CW     = pcc_pkg::CORR_W;
	localparam int COW    = pcc_pkg::COUNT_OUT_W;

	// Accumulation: products registered in stage 1, sums updated in stage 2.
	logic                    acc_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic signed [SAMPLE_WIDTH-1:0] y_s1;
	logic signed [PW-1:0]    xx_s1;
	logic signed [PW-1:0]    yy_s1;
	logic signed [PW-1:0]    xy_s1;

	logic [CNT_W-1:0]        pair_count_q;
	logic                    dropped_q;
	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;
	logic signed [SQ_W-1:0]  sum_xx_q;
	logic signed [SQ_W-1:0]  sum_yy_q;
	logic signed [SQ_W-1:0]  sum_xy_q;
	logic                    has_room;

	assign has_room = pair_count_q < CNT_W'(MAX_SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1       <= 1'b0;
			pair_count_q <= '0;
			dropped_q    <= 1'b0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			sum_xx_q     <= '0;
			sum_yy_q     <= '0;
			sum_xy_q     <= '0;
		end else if (cmd.out_load) begin
			acc_s1       <= 1'b0;
			pair_count_q <= '0;
			dropped_q    <= 1'b0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			sum_xx_q     <= '0;
			sum_yy_q     <= '0;
			sum_xy_q     <= '0;
		end else begin
			acc_s1 <= cmd.acc_en && has_room;
			if (cmd.acc_en) begin
				if (has_room) begin
					pair_count_q <= pair_count_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (acc_s1) begin
				sum_x_q  <= sum_x_q + SUM_W'(x_s1);
				sum_y_q  <= sum_y_q + SUM_W'(y_s1);
				sum_xx_q <= sum_xx_q + SQ_W'(xx_s1);
				sum_yy_q <= sum_yy_q + SQ_W'(yy_s1);
				sum_xy_q <= sum_xy_q + SQ_W'(xy_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			x_s1  <= x_sample;
			y_s1  <= y_sample;
			xx_s1 <= PW'(x_sample) * PW'(x_sample);
			yy_s1 <= PW'(y_sample) * PW'(y_sample);
			xy_s1 <= PW'(x_sample) * PW'(y_sample);
		end
	end

	// Magnitudes of the stored terms, fed to the unsigned multiplier.
	logic [SUM_W-1:0]         sx_mag;
	logic [SUM_W-1:0]         sy_mag;
	logic [SQ_W-1:0]          sxx_mag;
	logic [SQ_W-1:0]          syy_mag;
	logic [SQ_W-1:0]          sxy_mag;
	logic [PROD_W-1:0]        num_abs;

	logic signed [PROD_W-1:0] t_q;
	logic signed [PROD_W-1:0] num_q;
	logic signed [PROD_W-1:0] vx_q;
	logic signed [PROD_W-1:0] vy_q;
	logic [P_W-1:0]           p_q;
	logic [P_W-1:0]           m_q;

	assign sx_mag  = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
	assign sy_mag  = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
	assign sxx_mag = sum_xx_q;
	assign syy_mag = sum_yy_q;
	assign sxy_mag = sum_xy_q[SQ_W-1] ? SQ_W'(-sum_xy_q) : SQ_W'(sum_xy_q);
	assign num_abs = num_q[PROD_W-1] ? PROD_W'(-num_q) : PROD_W'(num_q);

	logic [OP_W-1:0] mul_a;
	logic [OP_W-1:0] mul_b;
	logic            mul_neg;
	logic            mul_done;
	logic [P_W-1:0]  mul_prod;

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (cmd.mul_sel)
			pcc_pkg::MS_N_SXY: begin
				mul_a   = OP_W'(pair_count_q);
				mul_b   = OP_W'(sxy_mag);
				mul_neg = sum_xy_q[SQ_W-1];
			end
			pcc_pkg::MS_SX_SY: begin
				mul_a   = OP_W'(sx_mag);
				mul_b   = OP_W'(sy_mag);
				mul_neg = sum_x_q[SUM_W-1] ^ sum_y_q[SUM_W-1];
			end
			pcc_pkg::MS_N_SXX: begin
				mul_a = OP_W'(pair_count_q);
				mul_b = OP_W'(sxx_mag);
			end
			pcc_pkg::MS_SX_SX: begin
				mul_a = OP_W'(sx_mag);
				mul_b = OP_W'(sx_mag);
			end
			pcc_pkg::MS_N_SYY: begin
				mul_a = OP_W'(pair_count_q);
				mul_b = OP_W'(syy_mag);
			end
			pcc_pkg::MS_SY_SY: begin
				mul_a = OP_W'(sy_mag);
				mul_b = OP_W'(sy_mag);
			end
			pcc_pkg::MS_VX_VY: begin
				mul_a = vx_q[VAR_W-1:0];
				mul_b = vy_q[VAR_W-1:0];
			end
			pcc_pkg::MS_C_C: begin
				mul_a = num_abs[VAR_W-1:0];
				mul_b = num_abs[VAR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	pcc_mul #(
		.OP_W (OP_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// The cross and square terms stay below 2^VAR_W in magnitude.
	logic [PROD_W-1:0]        prod_ext;
	logic signed [PROD_W-1:0] prod_s;

	assign prod_ext = PROD_W'(mul_prod[VAR_W-1:0]);
	assign prod_s   = mul_neg ? -signed'(prod_ext) : signed'(prod_ext);

	always_ff @(posedge clk) begin
		if (cmd.mul_wb) begin
			case (cmd.mul_sel)
				pcc_pkg::MS_N_SXY: t_q   <= prod_s;
				pcc_pkg::MS_SX_SY: num_q <= t_q - prod_s;
				pcc_pkg::MS_N_SXX: t_q   <= prod_s;
				pcc_pkg::MS_SX_SX: vx_q  <= t_q - prod_s;
				pcc_pkg::MS_N_SYY: t_q   <= prod_s;
				pcc_pkg::MS_SY_SY: vy_q  <= t_q - prod_s;
				pcc_pkg::MS_VX_VY: p_q   <= mul_prod;
				pcc_pkg::MS_C_C:   m_q   <= mul_prod;
				default: begin
				end
			endcase
		end
	end

	logic degen;
	assign degen = vx_q[PROD_W-1] || (vx_q == '0) || vy_q[PROD_W-1] || (vy_q == '0);

	logic          root_done;
	logic [CW-1:0] k;

	pcc_root #(
		.P_W (P_W)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.p      (p_q),
		.m      (m_q),
		.done   (root_done),
		.k      (k)
	);

	assign status.mul_done   = mul_done;
	assign status.root_done  = root_done;
	assign status.degenerate = degen;

	// Result register: zero for a degenerate run, else sign applied, positive side clamped below one.
	logic [CW-1:0]            corr_next;
	logic [CNT_W+COW-1:0]     count_wide;
	logic signed [CW-1:0]     corr_q;
	logic                     degenerate_q;
	logic                     overflowed_q;
	logic [COW-1:0]           sample_count_q;

	always_comb begin
		if (degen) begin
			corr_next = '0;
		end else if (num_q[PROD_W-1]) begin
			corr_next = CW'(0) - k;
		end else if (k[CW-1]) begin
			corr_next = pcc_pkg::CORR_MAX;
		end else begin
			corr_next = k;
		end
	end

	assign count_wide = {{COW{1'b0}}, pair_count_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			corr_q         <= signed'(corr_next);
			degenerate_q   <= degen;
			overflowed_q   <= dropped_q;
			sample_count_q <= count_wide[COW-1:0];
		end
	end

	assign corr         = corr_q;
	assign degenerate   = degenerate_q;
	assign overflowed   = overflowed_q;
	assign sample_count = sample_count_q;

endmodule

// ===== hdl/pcc_ctrl.sv =====
// Controller of the Pearson correlation core: input handshake, finishing sequence, result valid.
// Commands pcc_datapath through pcc_pkg::pcc_cmd_t and reads pcc_pkg::pcc_status_t.
module pcc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pcc_pkg::pcc_cmd_t    cmd,
	input  pcc_pkg::pcc_status_t status
);
	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_MUL,
		ST_MUL_WAIT,
		ST_CHECK,
		ST_ROOT,
		ST_ROOT_WAIT,
		ST_OUT
	} state_t;

	state_t            state_q;
	pcc_pkg::mul_sel_t sel_q;
	logic              out_valid_q;
	logic              out_free;

	assign in_ready       = state_q == ST_ACCUM;
	assign out_free       = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;

	assign cmd.acc_en     = in_valid && in_ready;
	assign cmd.mul_start  = state_q == ST_MUL;
	assign cmd.mul_wb     = (state_q == ST_MUL_WAIT) && status.mul_done;
	assign cmd.mul_sel    = sel_q;
	assign cmd.root_start = state_q == ST_ROOT;
	assign cmd.out_load   = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			sel_q       <= pcc_pkg::MS_N_SXY;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the old one in the same cycle it is taken.
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACCUM: begin
					if (cmd.acc_en && in_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					sel_q   <= pcc_pkg::MS_N_SXY;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (status.mul_done) begin
						case (sel_q)
							pcc_pkg::MS_N_SXY: begin
								sel_q   <= pcc_pkg::MS_SX_SY;
								state_q <= ST_MUL;
							end
							pcc_pkg::MS_SX_SY: begin
								sel_q   <= pcc_pkg::MS_N_SXX;
								state_q <= ST_MUL;
							end
							pcc_pkg::MS_N_SXX: begin
								sel_q   <= pcc_pkg::MS_SX_SX;
								state_q <= ST_MUL;
							end
							pcc_pkg::MS_SX_SX: begin
								sel_q   <= pcc_pkg::MS_N_SYY;
								state_q <= ST_MUL;
							end
							pcc_pkg::MS_N_SYY: begin
								sel_q   <= pcc_pkg::MS_SY_SY;
								state_q <= ST_MUL;
							end
							pcc_pkg::MS_SY_SY: begin
								state_q <= ST_CHECK;
							end
							pcc_pkg::MS_VX_VY: begin
								sel_q   <= pcc_pkg::MS_C_C;
								state_q <= ST_MUL;
							end
							pcc_pkg::MS_C_C: begin
								state_q <= ST_ROOT;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_CHECK: begin
					if (status.degenerate) begin
						state_q <= ST_OUT;
					end else begin
						sel_q   <= pcc_pkg::MS_VX_VY;
						state_q <= ST_MUL;
					end
				end
				ST_ROOT: begin
					state_q <= ST_ROOT_WAIT;
				end
				ST_ROOT_WAIT: begin
					if (status.root_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_ACCUM;
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

endmodule

// ===== hdl/pearson_correlation_core.sv =====
// Top level of the Pearson correlation core: controller plus datapath.
// Depends on pcc_pkg, pcc_in_if, pcc_out_if, pcc_ctrl and pcc_datapath.
//
//   Channel   Modport   Transaction carries
//   in_ch     sink      x_sample, y_sample (signed), last
//   out_ch    source    corr (signed Q1.15), degenerate, overflowed, sample_count
//
// Sample pairs are accepted one per cycle while a run is being accumulated. The
// pair that carries last starts the finishing sequence, during which the input
// stalls: a drain state, eight products on the shared digit-serial multiplier,
// then a restoring divide and a square root in the ratio unit; a degenerate run
// skips the last two products and the ratio unit. The result sits in an output
// register, so a stalled result channel only holds the core at the end of the
// next run. Reset clears the count, the sums and the dropped-pair flag at once;
// the result register itself is not reset.
module pearson_correlation_core #(
	parameter int MAX_SAMPLES  = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	pcc_in_if.sink   in_ch,
	pcc_out_if.source out_ch
);
	pcc_pkg::pcc_cmd_t    cmd;
	pcc_pkg::pcc_status_t status;

	// The controller owns every handshake signal; the datapath only sees payload.
	pcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	pcc_datapath #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.x_sample     (in_ch.x_sample),
		.y_sample     (in_ch.y_sample),
		.corr         (out_ch.corr),
		.degenerate   (out_ch.degenerate),
		.overflowed   (out_ch.overflowed),
		.sample_count (out_ch.sample_count)
	);

endmodule
